// ----- rtl/fba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the frame bitmap allocator.
// Used by every module of the block; depends on nothing else.
package fba_pkg;

  // Field widths of the request and result items.
  localparam int FRAME_W = 12;
  localparam int WORD_BITS = 32;
  localparam int BIT_W = 5;

  // Largest bitmap the block can hold and the default frame count.
  localparam int BITMAP_WORDS = 128;
  localparam int MAX_FRAMES_DEF = 4096;

  // Word count register.
  localparam int WCOUNT_W = 8;
  localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = 8'd128;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_MAPPED    = 2'd1,
    STAT_NO_FRAMES = 2'd2,
    STAT_IGNORED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE
  } state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [FRAME_W-1:0] current_frame;
    logic               kernel_page;
    logic               rw_page;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user_mode;
  } rsp_t;

  // Position of the lowest clear bit of a bitmap word.
  function automatic logic [BIT_W-1:0] first_clear(input logic [WORD_BITS-1:0] word);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        idx = BIT_W'(b);
      end
    end
    return idx;
  endfunction

endpackage

// ----- rtl/fba_bitmap_ram.sv -----
`timescale 1ns / 1ps
// Bitmap store: one synchronous memory word per 32 frames, with a registered read port.
// Per-word valid bits make a never-written word read as all zero after reset.
// Depends on fba_pkg.
module fba_bitmap_ram #(
  parameter int WORDS = fba_pkg::BITMAP_WORDS,
  parameter int IDX_W = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [IDX_W-1:0]               rd_addr,
  output logic [fba_pkg::WORD_BITS-1:0]  rd_data,
  input  logic                           wr_en,
  input  logic [IDX_W-1:0]               wr_addr,
  input  logic [fba_pkg::WORD_BITS-1:0]  wr_data
);

  logic [fba_pkg::WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]              valid;
  logic [fba_pkg::WORD_BITS-1:0] rd_word;
  logic                          rd_valid;

  // Valid bits are cleared by reset, so the whole bitmap reads as free.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

// ----- rtl/fba_ctrl.sv -----
`timescale 1ns / 1ps
// Request sequencer: scans the bitmap for allocations, does the read-modify-write
// for frees, and registers the result. Depends on fba_pkg.
module fba_ctrl #(
  parameter int WORDS = fba_pkg::BITMAP_WORDS,
  parameter int IDX_W = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  fba_pkg::req_t                  req,
  input  logic [fba_pkg::WCOUNT_W-1:0]   word_count,
  output logic                           busy,
  output logic                           done,
  output fba_pkg::rsp_t                  rsp,
  output logic                           rd_en,
  output logic [IDX_W-1:0]               rd_addr,
  input  logic [fba_pkg::WORD_BITS-1:0]  rd_data,
  output logic                           wr_en,
  output logic [IDX_W-1:0]               wr_addr,
  output logic [fba_pkg::WORD_BITS-1:0]  wr_data
);

  localparam logic [fba_pkg::WCOUNT_W-1:0] WORDS_CAP = fba_pkg::WCOUNT_W'(WORDS);

  fba_pkg::state_t                state, state_next;
  fba_pkg::req_t                  req_q, req_next;
  logic [fba_pkg::WCOUNT_W-1:0]   nw_q, nw_next;
  logic [IDX_W-1:0]               addr_q, addr_next;
  logic                           done_next;
  fba_pkg::rsp_t                  rsp_next;

  logic                           accept;
  logic [fba_pkg::WCOUNT_W-1:0]   nw_in;
  logic [fba_pkg::FRAME_W:0]      frames_in;
  logic                           start_scan, start_free;
  logic                           scan_hit, scan_last;
  logic [fba_pkg::BIT_W-1:0]      hit_bit;

  // Request decode and scan conditions.
  always_comb begin
    accept     = start && (state == fba_pkg::ST_IDLE);
    nw_in      = (word_count > WORDS_CAP) ? WORDS_CAP : word_count;
    frames_in  = {nw_in, {fba_pkg::BIT_W{1'b0}}};
    start_scan = accept && (req.cmd == fba_pkg::CMD_ALLOC)
                 && (req.current_frame == '0) && (nw_in != '0);
    start_free = accept && (req.cmd == fba_pkg::CMD_FREE)
                 && (req.current_frame != '0)
                 && ({1'b0, req.current_frame} < frames_in);
    scan_hit   = (rd_data != '1);
    scan_last  = (fba_pkg::WCOUNT_W'(addr_q) + 8'd1) == nw_q;
    hit_bit    = fba_pkg::first_clear(rd_data);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fba_pkg::ST_IDLE: begin
        if (start_scan) begin
          state_next = fba_pkg::ST_SCAN;
        end else if (start_free) begin
          state_next = fba_pkg::ST_FREE;
        end
      end
      fba_pkg::ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_next = fba_pkg::ST_IDLE;
        end
      end
      fba_pkg::ST_FREE: begin
        state_next = fba_pkg::ST_IDLE;
      end
      default: state_next = fba_pkg::ST_IDLE;
    endcase
  end

  // Memory control, result and capture registers.
  always_comb begin
    busy      = (state != fba_pkg::ST_IDLE);
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = addr_q;
    wr_data   = '0;
    done_next = 1'b0;
    rsp_next  = rsp;
    req_next  = req_q;
    nw_next   = nw_q;
    addr_next = addr_q;
    unique case (state)
      fba_pkg::ST_IDLE: begin
        if (accept) begin
          req_next  = req;
          nw_next   = nw_in;
          done_next = 1'b1;
          rsp_next  = '0;
          if (req.cmd == fba_pkg::CMD_ALLOC) begin
            if (req.current_frame != '0) begin
              rsp_next.status = fba_pkg::STAT_MAPPED;
              rsp_next.frame  = req.current_frame;
            end else if (nw_in == '0) begin
              rsp_next.status = fba_pkg::STAT_NO_FRAMES;
            end else begin
              done_next = 1'b0;
              rd_en     = 1'b1;
              rd_addr   = '0;
              addr_next = '0;
            end
          end else begin
            if (req.current_frame == '0) begin
              rsp_next.status = fba_pkg::STAT_IGNORED;
            end else if (!start_free) begin
              rsp_next.status = fba_pkg::STAT_IGNORED;
              rsp_next.frame  = req.current_frame;
            end else begin
              done_next = 1'b0;
              rd_en     = 1'b1;
              rd_addr   = IDX_W'(req.current_frame >> fba_pkg::BIT_W);
              addr_next = IDX_W'(req.current_frame >> fba_pkg::BIT_W);
            end
          end
        end
      end
      fba_pkg::ST_SCAN: begin
        if (scan_hit) begin
          // Claim the lowest free frame of this word.
          wr_en              = 1'b1;
          wr_data            = rd_data | (32'd1 << hit_bit);
          done_next          = 1'b1;
          rsp_next.status    = fba_pkg::STAT_DONE;
          rsp_next.frame     = fba_pkg::FRAME_W'({addr_q, hit_bit});
          rsp_next.present   = 1'b1;
          rsp_next.writable  = req_q.rw_page;
          rsp_next.user_mode = !req_q.kernel_page;
        end else if (scan_last) begin
          done_next       = 1'b1;
          rsp_next        = '0;
          rsp_next.status = fba_pkg::STAT_NO_FRAMES;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = addr_q + IDX_W'(1);
          addr_next = addr_q + IDX_W'(1);
        end
      end
      fba_pkg::ST_FREE: begin
        // Clear the frame's bit in the word read last cycle.
        wr_en     = 1'b1;
        wr_data   = rd_data & ~(32'd1 << req_q.current_frame[fba_pkg::BIT_W-1:0]);
        done_next = 1'b1;
        rsp_next  = '0;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fba_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_q  <= req_next;
    nw_q   <= nw_next;
    addr_q <= addr_next;
    rsp    <= rsp_next;
  end

endmodule

// ----- rtl/frame_bitmap_allocator_core.sv -----
`timescale 1ns / 1ps
// Top level of the first-fit page frame allocator: word count register,
// sequencer and bitmap memory. Depends on fba_pkg, fba_ctrl and fba_bitmap_ram.
//
// Usage:
//   A request (req) is taken at a rising edge with start high and busy low.
//   Each request gives exactly one result on rsp, marked by done for one cycle;
//   the receiver cannot stall, so results are never held.
//   Order of events from acceptance to the cycle done is high:
//     - already mapped, no frames in use, or ignored free: done the next cycle;
//     - free of a mapped frame: one read, then one write in the free state;
//     - allocate: the scan reads one bitmap word per cycle from the memory's
//       single read port and stops at the first word with a free frame, or
//       after the last word in use, which gives the no-frames result.
//   busy falls in the cycle done is shown, so the next request may follow.
//   The user must write the word count register (cfg_we, cfg_wdata) only while idle; the block does not enforce it.
//   Reset clears the per-word valid bits at once: the whole bitmap reads as
//   free, and the word count returns to 128. No clearing pass is needed.
module frame_bitmap_allocator_core #(
  parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  fba_pkg::req_t                 req,
  output logic                          done,
  output fba_pkg::rsp_t                 rsp,
  input  logic                          cfg_we,
  input  logic [fba_pkg::WCOUNT_W-1:0]  cfg_wdata
);

  localparam int WORDS = (MAX_FRAMES / fba_pkg::WORD_BITS < fba_pkg::BITMAP_WORDS)
                         ? MAX_FRAMES / fba_pkg::WORD_BITS : fba_pkg::BITMAP_WORDS;
  localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [fba_pkg::WCOUNT_W-1:0]  word_count;
  logic                          rd_en, wr_en;
  logic [IDX_W-1:0]              rd_addr, wr_addr;
  logic [fba_pkg::WORD_BITS-1:0] rd_data, wr_data;

  // Word count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= fba_pkg::WCOUNT_RESET;
    end else if (cfg_we) begin
      word_count <= cfg_wdata;
    end
  end

  fba_ctrl #(
    .WORDS (WORDS),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .word_count (word_count),
    .busy       (busy),
    .done       (done),
    .rsp        (rsp),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  fba_bitmap_ram #(
    .WORDS (WORDS),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // A result is only shown once the sequencer is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Flags are set only on a successful allocation.
  a_flags_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status != fba_pkg::STAT_DONE))
      |-> !(rsp.present || rsp.writable || rsp.user_mode))
    else $error("page flags on a failed request");

  // Busy rises only after an accepted request.
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a request");

endmodule
